>>> design/ahs_pkg.sv
package ahs_pkg;

  localparam int unsigned AXES  = 4;
  localparam int unsigned PINS  = 16;
  localparam int unsigned SLOTS = 4;

  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned PIN_W    = 4;
  localparam int unsigned ORDER_W  = SLOTS * SLOT_W;
  localparam int unsigned TRIG_W   = AXES * PIN_W;
  localparam int unsigned ELAPSED_W = 17;

  localparam logic [15:0] TIMEOUT_RESET = 16'd60000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HOME_ORDER      = 3'd0,
    REG_TRIGGER_PINS    = 3'd1,
    REG_TRIGGER_LEVELS  = 3'd2,
    REG_HOME_DIRECTIONS = 3'd3,
    REG_TIMEOUT_MS      = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_RUN     = 3'd1,
    ST_OK      = 3'd2,
    ST_CFG     = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_TRIG    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_APPROACH1 = 3'd0,
    PH_BACKOFF1  = 3'd1,
    PH_APPROACH2 = 3'd2,
    PH_BACKOFF2  = 3'd3,
    PH_DONE      = 3'd4
  } phase_e;

  typedef struct packed {
    logic [ORDER_W-1:0] home_order;
    logic [TRIG_W-1:0]  trigger_pins;
    logic [AXES-1:0]    trigger_levels;
    logic [AXES-1:0]    home_directions;
    logic [15:0]        timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [15:0]        pin_inputs;
    logic               move_done;
    logic signed [31:0] position;
  } item_t;

  typedef struct packed {
    status_e               status;
    phase_e                phase;
    logic [2:0]            axis;
    logic [2:0]            slot;
    logic [AXES-1:0]       homed;
    logic [ELAPSED_W-1:0]  elapsed;
    logic signed [31:0]    capture;
  } state_t;

  typedef struct packed {
    status_e            status;
    logic [2:0]         axis;
    phase_e             phase;
    logic               move_start;
    logic               move_dir;
    logic [3:0]         homed_mask;
    logic               axis_done;
    logic signed [31:0] captured_position;
    logic               estop_request;
  } result_t;

endpackage

>>> design/ahs_step.sv
module ahs_step import ahs_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  typedef struct packed {
    status_e    status;
    phase_e     phase;
    logic [2:0] axis;
    logic       issue;
    logic       dir;
  } begin_t;

  // Take the axis held in a slot: end of list, bad slot, or a fresh approach.
  function automatic begin_t begin_slot(logic [ORDER_W-1:0] order,
                                        logic [AXES-1:0] dirs, logic [2:0] slot);
    begin_t     b;
    logic [2:0] v;
    v = (slot < 3'(SLOTS)) ? order[slot[1:0]*SLOT_W +: SLOT_W] : 3'd0;
    b.status = ST_RUN;
    b.phase  = PH_APPROACH1;
    b.axis   = v;
    b.issue  = 1'b0;
    b.dir    = 1'b0;
    if (v == 3'd0) begin
      b.status = ST_OK;
      b.axis   = 3'd0;
      b.phase  = PH_DONE;
    end else if (v > 3'(AXES)) begin
      b.status = ST_CFG;
      b.axis   = 3'd0;
      b.phase  = PH_DONE;
    end else begin
      b.issue = 1'b1;
      b.dir   = dirs[2'(v - 3'd1)];
    end
    return b;
  endfunction

  logic                 fail_hit;
  status_e              fail_code;
  logic [AXES-1:0]      clear_mask;
  logic [2:0]           v;
  logic [1:0]           vidx;
  logic [PIN_W-1:0]     pin;
  logic [1:0]           cur_idx;
  logic [PIN_W-1:0]     cur_pin;
  logic                 cur_hit;
  logic [ELAPSED_W-1:0] el_inc;
  begin_t               b_first;
  begin_t               b_next;
  state_t               nxt;
  logic                 mstart;
  logic                 mdir;
  logic                 adone;
  logic                 estop;

  // Start checks over the listed slots; first failing slot decides
  always_comb begin
    fail_hit   = 1'b0;
    fail_code  = ST_CFG;
    clear_mask = '0;
    v          = 3'd0;
    vidx       = 2'd0;
    pin        = '0;
    for (int s = 0; s < SLOTS; s++) begin
      v    = cfg_i.home_order[s*SLOT_W +: SLOT_W];
      vidx = 2'(v - 3'd1);
      pin  = cfg_i.trigger_pins[vidx*PIN_W +: PIN_W];
      if (v != 3'd0 && v <= 3'(AXES)) begin
        clear_mask[vidx] = 1'b1;
        if (!fail_hit) begin
          if ({1'b0, pin} >= 5'(PINS)) begin
            fail_hit  = 1'b1;
            fail_code = ST_CFG;
          end else if (item_i.pin_inputs[pin] == cfg_i.trigger_levels[vidx]) begin
            fail_hit  = 1'b1;
            fail_code = ST_TRIG;
          end
        end
      end
    end
  end

  assign cur_idx = 2'(state_i.axis - 3'd1);
  assign cur_pin = cfg_i.trigger_pins[cur_idx*PIN_W +: PIN_W];
  assign cur_hit = item_i.pin_inputs[cur_pin] == cfg_i.trigger_levels[cur_idx];
  assign el_inc  = (state_i.elapsed != '1) ? state_i.elapsed + 1'b1 : state_i.elapsed;
  assign b_first = begin_slot(cfg_i.home_order, cfg_i.home_directions, 3'd0);
  assign b_next  = begin_slot(cfg_i.home_order, cfg_i.home_directions,
                              state_i.slot + 3'd1);

  always_comb begin
    nxt    = state_i;
    mstart = 1'b0;
    mdir   = 1'b0;
    adone  = 1'b0;
    estop  = 1'b0;
    if (!item_i.op) begin
      if (state_i.status != ST_RUN) begin
        if (fail_hit) begin
          nxt.status = fail_code;
          nxt.phase  = PH_DONE;
          nxt.axis   = 3'd0;
        end else begin
          nxt.homed  = state_i.homed & ~clear_mask;
          nxt.slot   = 3'd0;
          nxt.status = b_first.status;
          nxt.phase  = b_first.phase;
          nxt.axis   = b_first.axis;
          if (b_first.issue) begin
            nxt.elapsed = '0;
            mstart      = 1'b1;
            mdir        = b_first.dir;
          end
        end
      end
    end else if (state_i.status == ST_RUN && state_i.axis != 3'd0
                 && state_i.axis <= 3'(AXES)) begin
      case (state_i.phase)
        PH_APPROACH1, PH_APPROACH2: begin
          nxt.elapsed = el_inc;
          if (el_inc > {1'b0, cfg_i.timeout_ms}) begin
            nxt.status = ST_TIMEOUT;
            nxt.phase  = PH_DONE;
            estop      = 1'b1;
          end else if (cur_hit) begin
            nxt.phase = (state_i.phase == PH_APPROACH1) ? PH_BACKOFF1 : PH_BACKOFF2;
            mstart    = 1'b1;
            mdir      = ~cfg_i.home_directions[cur_idx];
          end
        end
        PH_BACKOFF1: begin
          if (item_i.move_done) begin
            nxt.phase   = PH_APPROACH2;
            nxt.elapsed = '0;
            mstart      = 1'b1;
            mdir        = cfg_i.home_directions[cur_idx];
          end
        end
        PH_BACKOFF2: begin
          if (item_i.move_done) begin
            nxt.capture        = item_i.position;
            nxt.homed[cur_idx] = 1'b1;
            adone              = 1'b1;
            nxt.slot           = state_i.slot + 3'd1;
            nxt.status         = b_next.status;
            nxt.phase          = b_next.phase;
            nxt.axis           = b_next.axis;
            if (b_next.issue) begin
              nxt.elapsed = '0;
              mstart      = 1'b1;
              mdir        = b_next.dir;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o = nxt;

  assign result_o.status            = nxt.status;
  assign result_o.axis              = nxt.axis;
  assign result_o.phase             = nxt.phase;
  assign result_o.move_start        = mstart;
  assign result_o.move_dir          = mstart & mdir;
  assign result_o.homed_mask        = nxt.homed;
  assign result_o.axis_done         = adone;
  assign result_o.captured_position = nxt.capture;
  assign result_o.estop_request     = estop;

endmodule

>>> design/axis_homing_sequencer_core.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  op, pin_inputs, move_done, position
// result    out        out_valid_o/out_stall_i status .. estop_request
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low; a result passes the input
// register, then the result register, with the single-pass step logic between them.
// Reset clears the sequencer state and loads register defaults (timeout 60000).
// An output stall backs up into in_stall_o only once both the input register
// and the result register hold a beat. Config writes are always taken.
module axis_homing_sequencer_core import ahs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [15:0]        pin_inputs_i,
  input  logic               move_done_i,
  input  logic signed [31:0] position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [2:0]         axis_o,
  output logic [2:0]         phase_o,
  output logic               move_start_o,
  output logic               move_dir_o,
  output logic [3:0]         homed_mask_o,
  output logic               axis_done_o,
  output logic signed [31:0] captured_position_o,
  output logic               estop_request_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  item_t   item_q;
  result_t result_q;
  result_t result_d;
  logic    s1_valid_q;
  logic    out_valid_q;
  logic    s1_adv;
  logic    in_acc;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  ahs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_order      <= '0;
      cfg_q.trigger_pins    <= '0;
      cfg_q.trigger_levels  <= '0;
      cfg_q.home_directions <= '0;
      cfg_q.timeout_ms      <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_HOME_ORDER:      cfg_q.home_order      <= cfg_data_i[ORDER_W-1:0];
        REG_TRIGGER_PINS:    cfg_q.trigger_pins    <= cfg_data_i[TRIG_W-1:0];
        REG_TRIGGER_LEVELS:  cfg_q.trigger_levels  <= cfg_data_i[AXES-1:0];
        REG_HOME_DIRECTIONS: cfg_q.home_directions <= cfg_data_i[AXES-1:0];
        REG_TIMEOUT_MS:      cfg_q.timeout_ms      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      state_q.status  <= ST_IDLE;
      state_q.phase   <= PH_DONE;
      state_q.axis    <= '0;
      state_q.slot    <= '0;
      state_q.homed   <= '0;
      state_q.elapsed <= '0;
      state_q.capture <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the beat until it moves on
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.op         <= op_i;
      item_q.pin_inputs <= pin_inputs_i;
      item_q.move_done  <= move_done_i;
      item_q.position   <= position_i;
    end
    if (s1_adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = result_q.status;
  assign axis_o              = result_q.axis;
  assign phase_o             = result_q.phase;
  assign move_start_o        = result_q.move_start;
  assign move_dir_o          = result_q.move_dir;
  assign homed_mask_o        = result_q.homed_mask;
  assign axis_done_o         = result_q.axis_done;
  assign captured_position_o = result_q.captured_position;
  assign estop_request_o     = result_q.estop_request;

endmodule
